>>> src/graph_traversal_order_defines.svh
// assertion macros for the graph traversal order block
// used by the port checker; expects clk and arst_n in scope
`ifndef GRAPH_TRAVERSAL_ORDER_DEFINES_SVH
`define GRAPH_TRAVERSAL_ORDER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define GTO_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define GTO_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/gto_pkg.sv
// shared types, sizes and codes for the graph traversal order block
// no dependencies; imported by the top level, the sequencer and the checker
package gto_pkg;

	localparam int MAX_VERTICES = 16;
	localparam int MAX_EDGES    = 32;
	localparam int VTX_W        = 4;
	localparam int EDGE_W       = 2 * VTX_W;
	localparam int EDGE_AW      = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int CNT_W        = $clog2(MAX_EDGES + 1);
	localparam int WORK_DEPTH   = 2 * MAX_EDGES + 1;
	localparam int WORK_AW      = $clog2(WORK_DEPTH);
	localparam int PTR_W        = $clog2(WORK_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_ADD      = 2'd0,
		OP_TRAVERSE = 2'd1,
		OP_CLEAR    = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STAT_VISIT = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_POP_WAIT,
		S_EMIT,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]       op;
		logic [VTX_W-1:0] endpoint_a;
		logic [VTX_W-1:0] endpoint_b;
		logic [VTX_W-1:0] start_vertex;
	} gto_in_t;

	typedef struct packed {
		logic [VTX_W-1:0] vertex_out;
		logic             last_visit;
		logic [1:0]       status;
	} gto_out_t;

	// one result handed from the sequencer to the output register
	typedef struct packed {
		logic     vld;
		gto_out_t data;
	} res_t;

	typedef struct packed {
		logic               we;
		logic [EDGE_AW-1:0] waddr;
		logic [EDGE_W-1:0]  wdata;
		logic [EDGE_AW-1:0] raddr;
	} edge_req_t;

	typedef struct packed {
		logic               we;
		logic [WORK_AW-1:0] waddr;
		logic [VTX_W-1:0]   wdata;
		logic [WORK_AW-1:0] raddr;
	} work_req_t;

	function automatic logic in_range(input logic [VTX_W-1:0] v);
		return int'(v) < MAX_VERTICES;
	endfunction

endpackage

>>> src/graph_traversal_order.sv
// top level of the graph traversal order block: ports, mode register, output register
// depends on gto_pkg, gto_ram and gto_seq
//
// Holds up to MAX_EDGES undirected edges in an edge store with one read port and walks them
// breadth-first (queue) or depth-first (stack) from a start vertex, sending the
// visited vertices out in order with the last one flagged. A rejected item gives
// one status result. A traversal runs longer while the sink stalls: the edge
// store has one read port, so every expansion scans the stored edges one per cycle.
// The input stalls for the whole traversal; the output register lets a finished
// result wait for the sink. The mode register should only be written while no
// traversal is running.
module graph_traversal_order
	import gto_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  gto_in_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output gto_out_t out_data,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  logic     cfg_data
);

	logic              mode_q;
	logic              out_vld_q;
	gto_out_t          out_q;
	logic              idle, out_free, in_accept;
	res_t              res;
	edge_req_t         edge_req;
	work_req_t         work_req;
	logic [EDGE_W-1:0] edge_rdata;
	logic [VTX_W-1:0]  work_rdata;

	assign out_free  = !out_vld_q || !out_stall;
	assign in_stall  = !idle || !out_free;
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_data;
			end
			if (res.vld) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res.vld) begin
			out_q <= res.data;
		end
	end

	gto_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (mode_q),
		.in_accept  (in_accept),
		.in_data    (in_data),
		.out_free   (out_free),
		.idle       (idle),
		.res        (res),
		.edge_req   (edge_req),
		.edge_rdata (edge_rdata),
		.work_req   (work_req),
		.work_rdata (work_rdata)
	);

	gto_ram #(
		.WIDTH (EDGE_W),
		.DEPTH (MAX_EDGES)
	) u_edge_ram (
		.clk   (clk),
		.we    (edge_req.we),
		.waddr (edge_req.waddr),
		.wdata (edge_req.wdata),
		.raddr (edge_req.raddr),
		.rdata (edge_rdata)
	);

	gto_ram #(
		.WIDTH (VTX_W),
		.DEPTH (WORK_DEPTH)
	) u_work_ram (
		.clk   (clk),
		.we    (work_req.we),
		.waddr (work_req.waddr),
		.wdata (work_req.wdata),
		.raddr (work_req.raddr),
		.rdata (work_rdata)
	);

endmodule

>>> src/gto_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module gto_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/gto_seq.sv
// traversal sequencer: edge count, visited map, work list pointers and the fsm
// depends on gto_pkg; drives the edge store and work list rams
module gto_seq
	import gto_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              mode,
	input  logic              in_accept,
	input  gto_in_t           in_data,
	input  logic              out_free,
	output logic              idle,
	output res_t              res,
	output edge_req_t         edge_req,
	input  logic [EDGE_W-1:0] edge_rdata,
	output work_req_t         work_req,
	input  logic [VTX_W-1:0]  work_rdata
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]        edge_total_q, edge_total_d;
	logic [MAX_VERTICES-1:0] visited_q, visited_d;
	logic [PTR_W-1:0]        head_q, head_d;
	logic [PTR_W-1:0]        tail_q, tail_d;
	logic [VTX_W-1:0]        u_q, u_d;
	logic                    pend_vld_q, pend_vld_d;
	logic [VTX_W-1:0]        pend_q, pend_d;
	logic [CNT_W-1:0]        scan_q, scan_d;
	logic                    scan_vld_s1, scan_vld_d;

	logic [PTR_W-1:0] top_m1;
	logic [VTX_W-1:0] ea, eb, nbr;
	logic             hit;

	assign top_m1 = tail_q - PTR_W'(1);
	assign ea     = edge_rdata[EDGE_W-1:VTX_W];
	assign eb     = edge_rdata[VTX_W-1:0];
	assign idle   = (state_q == S_IDLE);

	// neighbour of u in the edge read back this cycle
	always_comb begin
		hit = 1'b0;
		nbr = eb;
		if (ea == u_q) begin
			hit = 1'b1;
			nbr = eb;
		end else if (eb == u_q) begin
			hit = 1'b1;
			nbr = ea;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			edge_total_q <= '0;
			visited_q    <= '0;
			pend_vld_q   <= 1'b0;
			scan_vld_s1  <= 1'b0;
		end else begin
			state_q      <= state_d;
			edge_total_q <= edge_total_d;
			visited_q    <= visited_d;
			pend_vld_q   <= pend_vld_d;
			scan_vld_s1  <= scan_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		head_q <= head_d;
		tail_q <= tail_d;
		u_q    <= u_d;
		pend_q <= pend_d;
		scan_q <= scan_d;
	end

	always_comb begin
		state_d      = state_q;
		edge_total_d = edge_total_q;
		visited_d    = visited_q;
		head_d       = head_q;
		tail_d       = tail_q;
		u_d          = u_q;
		pend_vld_d   = pend_vld_q;
		pend_d       = pend_q;
		scan_d       = scan_q;
		scan_vld_d   = 1'b0;

		res.vld             = 1'b0;
		res.data.vertex_out = pend_q;
		res.data.last_visit = 1'b0;
		res.data.status     = STAT_VISIT;

		edge_req.we    = 1'b0;
		edge_req.waddr = edge_total_q[EDGE_AW-1:0];
		edge_req.wdata = {in_data.endpoint_a, in_data.endpoint_b};
		edge_req.raddr = scan_q[EDGE_AW-1:0];

		work_req.we    = 1'b0;
		work_req.waddr = tail_q[WORK_AW-1:0];
		work_req.wdata = nbr;
		work_req.raddr = mode ? top_m1[WORK_AW-1:0] : head_q[WORK_AW-1:0];

		unique case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					unique case (in_data.op)
						OP_ADD: begin
							if (!in_range(in_data.endpoint_a) ||
							    !in_range(in_data.endpoint_b)) begin
								res.vld             = 1'b1;
								res.data.vertex_out = '0;
								res.data.last_visit = 1'b1;
								res.data.status     = STAT_RANGE;
							end else if (int'(edge_total_q) >= MAX_EDGES) begin
								res.vld             = 1'b1;
								res.data.vertex_out = '0;
								res.data.last_visit = 1'b1;
								res.data.status     = STAT_FULL;
							end else begin
								edge_req.we  = 1'b1;
								edge_total_d = edge_total_q + CNT_W'(1);
							end
						end
						OP_TRAVERSE: begin
							if (!in_range(in_data.start_vertex)) begin
								res.vld             = 1'b1;
								res.data.vertex_out = '0;
								res.data.last_visit = 1'b1;
								res.data.status     = STAT_RANGE;
							end else begin
								work_req.we    = 1'b1;
								work_req.waddr = '0;
								work_req.wdata = in_data.start_vertex;
								// breadth-first marks on enqueue, depth-first on pop
								visited_d      = mode ? '0 :
									(MAX_VERTICES'(1) << in_data.start_vertex);
								head_d         = '0;
								tail_d         = PTR_W'(1);
								pend_vld_d     = 1'b0;
								state_d        = S_POP;
							end
						end
						OP_CLEAR: begin
							edge_total_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			S_POP: begin
				if (mode ? (tail_q == '0) : (head_q == tail_q)) begin
					state_d = S_DONE;
				end else begin
					if (mode) begin
						tail_d = top_m1;
					end else begin
						head_d = head_q + PTR_W'(1);
					end
					state_d = S_POP_WAIT;
				end
			end
			S_POP_WAIT: begin
				u_d = work_rdata;
				if (mode && visited_q[work_rdata]) begin
					state_d = S_POP;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				// the held vertex is known not to be last once another one is visited
				if (!pend_vld_q || out_free) begin
					res.vld    = pend_vld_q;
					pend_vld_d = 1'b1;
					pend_d     = u_q;
					if (mode) begin
						visited_d[u_q] = 1'b1;
					end
					scan_d  = '0;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_q < edge_total_q) begin
					scan_d     = scan_q + CNT_W'(1);
					scan_vld_d = 1'b1;
				end
				if (scan_vld_s1 && hit && !visited_q[nbr] && int'(tail_q) < WORK_DEPTH) begin
					work_req.we = 1'b1;
					tail_d      = tail_q + PTR_W'(1);
					if (!mode) begin
						visited_d[nbr] = 1'b1;
					end
				end
				if (scan_q == edge_total_q && !scan_vld_s1) begin
					state_d = S_POP;
				end
			end
			S_DONE: begin
				if (out_free) begin
					res.vld             = 1'b1;
					res.data.last_visit = 1'b1;
					pend_vld_d          = 1'b0;
					state_d             = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> src/gto_checker.sv
// port-level checker for graph_traversal_order, attached by bind
// depends on gto_pkg and graph_traversal_order_defines.svh
`include "graph_traversal_order_defines.svh"

module gto_checker
	import gto_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_stall,
	input gto_in_t  in_data,
	input logic     out_valid,
	input logic     out_stall,
	input gto_out_t out_data
);

	// a rejection is always a single result, so it closes its item
	`GTO_ASSERT_NOW(a_reject_is_last, out_valid && out_data.status != STAT_VISIT, out_data.last_visit, "rejection result not flagged last")

	// a started traversal holds off the next input
	`GTO_ASSERT_NEXT(a_trav_blocks_input, in_valid && !in_stall && in_data.op == OP_TRAVERSE && int'(in_data.start_vertex) < MAX_VERTICES, in_stall, "input taken during traversal")

	// a stalled result keeps its value
	`GTO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind graph_traversal_order gto_checker u_gto_checker (.*);

>>> dv/graph_traversal_order_test.sv
// self-checking testbench for graph_traversal_order: breadth-first and depth-first walks
// an in-bench graph predictor feeds an in-order scoreboard; random sender gaps and sink stalls
// depends on gto_pkg and the graph_traversal_order rtl only
module graph_traversal_order_test
	import gto_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 50;
	localparam int ITEM_TARGET = 430;
	localparam int LIMIT_NS = 20_000_000;

	typedef enum int {SINK_READY, SINK_LIGHT, SINK_HEAVY, SINK_PERIODIC} sink_pattern_t;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_stall;
	gto_in_t  in_data;
	logic     out_valid;
	logic     out_stall;
	gto_out_t out_data;
	logic     cfg_valid;
	logic     cfg_ready;
	logic     cfg_data;

	// predictor state
	bit               walk_mode;
	logic [VTX_W-1:0] edge_from [MAX_EDGES];
	logic [VTX_W-1:0] edge_to [MAX_EDGES];
	int               edge_count;
	gto_out_t         expected_visits[$];

	int            mismatches;
	int            counted_items;
	int            burst_left;
	bit            offering;
	int            hold_request;
	int            hold_left;
	int            pattern_left;
	sink_pattern_t stall_pattern;

	graph_traversal_order dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#(LIMIT_NS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic void expect_result(gto_out_t r);
		expected_visits = {expected_visits, r};
	endfunction

	function automatic void push_status(status_t st);
		gto_out_t r;
		r.vertex_out = '0;
		r.last_visit = 1'b1;
		r.status     = st;
		expect_result(r);
	endfunction

	// walk the stored graph from start and queue the visit order
	function automatic void walk_graph(logic [VTX_W-1:0] start);
		logic [VTX_W-1:0]        work [WORK_DEPTH];
		logic [MAX_VERTICES-1:0] seen;
		logic [VTX_W-1:0]        u;
		logic [VTX_W-1:0]        n;
		int                      head;
		int                      tail;
		int                      top;
		int                      emitted;
		bit                      hit;
		gto_out_t                r;
		seen = '0;
		emitted = 0;
		r.last_visit = 1'b0;
		r.status = STAT_VISIT;
		if (!walk_mode) begin
			head = 0;
			work[0] = start;
			tail = 1;
			seen[start] = 1'b1;
			while (head < tail) begin
				u = work[head];
				head++;
				if (emitted < MAX_VERTICES) begin
					r.vertex_out = u;
					expect_result(r);
					emitted++;
				end
				for (int i = 0; i < edge_count; i++) begin
					hit = 1'b1;
					n = '0;
					if (edge_from[i] == u) n = edge_to[i];
					else if (edge_to[i] == u) n = edge_from[i];
					else hit = 1'b0;
					if (hit && !seen[n] && tail < WORK_DEPTH) begin
						seen[n] = 1'b1;
						work[tail] = n;
						tail++;
					end
				end
			end
		end else begin
			work[0] = start;
			top = 1;
			while (top > 0) begin
				top--;
				u = work[top];
				if (seen[u]) continue;
				seen[u] = 1'b1;
				if (emitted < MAX_VERTICES) begin
					r.vertex_out = u;
					expect_result(r);
					emitted++;
				end
				for (int i = 0; i < edge_count; i++) begin
					hit = 1'b1;
					n = '0;
					if (edge_from[i] == u) n = edge_to[i];
					else if (edge_to[i] == u) n = edge_from[i];
					else hit = 1'b0;
					if (hit && !seen[n] && top < WORK_DEPTH) begin
						work[top] = n;
						top++;
					end
				end
			end
		end
		if (emitted > 0) begin
			expected_visits[expected_visits.size() - 1].last_visit = 1'b1;
		end
	endfunction

	function automatic void apply_graph_item(gto_in_t item);
		case (item.op)
			OP_ADD: begin
				if (int'(item.endpoint_a) >= MAX_VERTICES || int'(item.endpoint_b) >= MAX_VERTICES)
					push_status(STAT_RANGE);
				else if (edge_count >= MAX_EDGES)
					push_status(STAT_FULL);
				else begin
					edge_from[edge_count] = item.endpoint_a;
					edge_to[edge_count] = item.endpoint_b;
					edge_count++;
				end
			end
			OP_TRAVERSE: begin
				if (int'(item.start_vertex) >= MAX_VERTICES) push_status(STAT_RANGE);
				else walk_graph(item.start_vertex);
			end
			OP_CLEAR: edge_count = 0;
			default: ;
		endcase
	endfunction

	function automatic gto_in_t make_item(logic [1:0] op, logic [VTX_W-1:0] a,
			logic [VTX_W-1:0] b, logic [VTX_W-1:0] s);
		gto_in_t item;
		item.op = op;
		item.endpoint_a = a;
		item.endpoint_b = b;
		item.start_vertex = s;
		return item;
	endfunction

	function automatic logic [VTX_W-1:0] pick_vertex(int base, int span);
		return VTX_W'(base + $urandom_range(0, span - 1));
	endfunction

	// result checker
	always @(posedge clk) begin
		gto_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_visits.size() == 0) begin
				$display("%0t unexpected result: expected none, actual vertex %0d last %0b status %0d",
					$time, out_data.vertex_out, out_data.last_visit, out_data.status);
				mismatches++;
			end else begin
				want = expected_visits.pop_front();
				if (out_data.vertex_out !== want.vertex_out) begin
					$display("%0t vertex_out: expected %0d actual %0d",
						$time, want.vertex_out, out_data.vertex_out);
					mismatches++;
				end
				if (out_data.last_visit !== want.last_visit) begin
					$display("%0t last_visit: expected %0b actual %0b",
						$time, want.last_visit, out_data.last_visit);
					mismatches++;
				end
				if (out_data.status !== want.status) begin
					$display("%0t status: expected %0d actual %0d",
						$time, want.status, out_data.status);
					mismatches++;
				end
			end
		end
	end

	// sink stall patterns, with a long hold-off on request
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (pattern_left == 0) begin
				stall_pattern = sink_pattern_t'($urandom_range(0, 3));
				pattern_left = $urandom_range(8, 80);
			end
			pattern_left--;
			case (stall_pattern)
				SINK_READY:  out_stall <= 1'b0;
				SINK_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
				SINK_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
				default:     out_stall <= (pattern_left % 3 == 0);
			endcase
		end
	end

	task automatic send_item(gto_in_t item);
		int gap;
		in_valid <= 1'b1;
		in_data <= item;
		offering = 1'b1;
		do @(posedge clk); while (in_stall);
		apply_graph_item(item);
		if (item.op != OP_UNUSED) counted_items++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
			burst_left = $urandom_range(0, 8);
			in_valid <= 1'b0;
			offering = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic add_edge(logic [VTX_W-1:0] a, logic [VTX_W-1:0] b);
		send_item(make_item(OP_ADD, a, b, VTX_W'($urandom)));
	endtask

	task automatic traverse(logic [VTX_W-1:0] s);
		send_item(make_item(OP_TRAVERSE, VTX_W'($urandom), VTX_W'($urandom), s));
	endtask

	task automatic clear_store();
		send_item(make_item(OP_CLEAR, VTX_W'($urandom), VTX_W'($urandom), VTX_W'($urandom)));
	endtask

	// stop offering and wait for every expected transfer
	task automatic drain_results();
		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
		while (expected_visits.size() != 0) @(posedge clk);
	endtask

	task automatic set_walk_mode(bit m);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		walk_mode = m;
	endtask

	task automatic test_directed_walks();
		set_walk_mode(1'b0);
		traverse(4'd5);
		add_edge(4'd0, 4'd1);
		add_edge(4'd1, 4'd2);
		add_edge(4'd0, 4'd3);
		add_edge(4'd3, 4'd3);
		add_edge(4'd15, 4'd0);
		add_edge(4'd2, 4'd15);
		traverse(4'd0);
		send_item(make_item(OP_UNUSED, 4'd15, 4'd15, 4'd15));
		traverse(4'd15);
		traverse(4'd9);
		set_walk_mode(1'b1);
		traverse(4'd0);
		traverse(4'd15);
		traverse(4'd3);
		clear_store();
		traverse(4'd0);
		add_edge(4'd15, 4'd15);
		traverse(4'd15);
	endtask

	// chain through every vertex, then fill the store past its end
	task automatic test_store_full();
		int extra;
		set_walk_mode(1'b0);
		clear_store();
		for (int k = 0; k < MAX_VERTICES - 1; k++) add_edge(VTX_W'(k), VTX_W'(k + 1));
		extra = MAX_EDGES - (MAX_VERTICES - 1) + $urandom_range(1, 3);
		repeat (extra) add_edge(VTX_W'($urandom), VTX_W'($urandom));
		traverse(4'd0);
		traverse(VTX_W'($urandom));
		set_walk_mode(1'b1);
		traverse(4'd15);
		traverse(VTX_W'($urandom));
	endtask

	// sink holds off while the sender keeps offering, so the input backs up
	task automatic test_output_backpressure();
		set_walk_mode(bit'($urandom_range(0, 1)));
		clear_store();
		for (int k = 0; k < MAX_VERTICES - 1; k++) add_edge(VTX_W'(k), VTX_W'($urandom_range(0, 15)));
		drain_results();
		hold_request = 400;
		repeat (6) traverse(VTX_W'($urandom));
		add_edge(VTX_W'($urandom), VTX_W'($urandom));
		traverse(VTX_W'($urandom));
		drain_results();
	endtask

	task automatic test_random_sequences();
		int span;
		int base;
		int n_edges;
		while (counted_items < ITEM_TARGET) begin
			if ($urandom_range(0, 4) == 0) set_walk_mode(bit'($urandom_range(0, 1)));
			if ($urandom_range(0, 4) != 0) begin
				if ($urandom_range(0, 3) != 0) clear_store();
				span = $urandom_range(2, MAX_VERTICES);
				base = $urandom_range(0, MAX_VERTICES - span);
				n_edges = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 36) : $urandom_range(0, 12);
				repeat (n_edges) begin
					if ($urandom_range(0, 9) == 0) add_edge(VTX_W'($urandom), VTX_W'($urandom));
					else add_edge(pick_vertex(base, span), pick_vertex(base, span));
					if ($urandom_range(0, 15) == 0) traverse(pick_vertex(base, span));
				end
				repeat ($urandom_range(1, 3)) begin
					if ($urandom_range(0, 5) == 0) traverse(VTX_W'($urandom));
					else traverse(pick_vertex(base, span));
				end
			end else begin
				repeat ($urandom_range(1, 6))
					send_item(make_item(2'($urandom_range(0, 3)), VTX_W'($urandom),
						VTX_W'($urandom), VTX_W'($urandom)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		walk_mode = 1'b0;
		edge_count = 0;
		mismatches = 0;
		counted_items = 0;
		burst_left = 0;
		offering = 1'b0;
		hold_request = 0;
		hold_left = 0;
		pattern_left = 0;
		stall_pattern = SINK_READY;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_walks();
		test_store_full();
		test_output_backpressure();
		test_random_sequences();

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_visits.size() != 0) mismatches++;
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
